FILE: rtl/rcv_pkg.sv
package rcv_pkg;

    // fixed field widths
    localparam int VALUE_W       = 32;
    localparam int RANK_W        = 6;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 8;

    // default list capacity
    localparam int MAX_ITEMS_DEF = 64;

    // control from the sequencer to the compare unit, in the cycle after the read
    typedef struct packed {
        logic load_cur;   // read data is the element being ranked
        logic acc_en;     // read data is a list element to compare against
    } rk_ctrl_t;

endpackage

FILE: rtl/rank_compress_values_core.sv
// rank compression of a list of signed 32-bit values
//
// input channel (s_): one list element per item, s_tdata holds the value,
// s_tlast marks the final element. items are taken one per cycle while the
// block is loading; elements beyond MAX_ITEMS are dropped, but a dropped
// element with s_tlast still starts the ranking of what was stored.
// after the final element s_tready stays low until every rank has been
// computed and handed to the output register.
// result channel (m_): one item per stored element, in load order,
// m_tdata[5:0] is the count of stored values strictly smaller than it,
// m_tlast marks the rank of the last stored element.
// each rank of a list of n elements is computed in steps: one read of the
// element, n reads of the value store through its single read port with one
// comparison each, a drain step and an output step.
// a stalled receiver holds the output register; the sequencer then waits
// with the next rank finished until the register frees up.
// reset empties the list and clears the output valid flag; the value store
// itself is not cleared, only written entries are ever used.
module rank_compress_values_core #(
    parameter int MAX_ITEMS = rcv_pkg::MAX_ITEMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rcv_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                          s_tlast,   // last_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rcv_pkg::M_TDATA_W-1:0] m_tdata,   // [5:0] rank, [7:6] zero
    output logic                          m_tlast    // last_out
);
    import rcv_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_FETCH  = 5'b00010,
        ST_SWEEP  = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_i_reg, idx_i_next;
    logic [IDX_W-1:0]   idx_j_reg, idx_j_next;
    rk_ctrl_t           ctrl_reg, ctrl_next;
    logic               m_valid_reg, m_valid_next;
    logic [RANK_W-1:0]  m_rank_reg, m_rank_next;
    logic               m_last_reg, m_last_next;

    logic               s_accept;
    logic               full;
    logic               wr_en;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   count_m1;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic [RANK_W-1:0]  rank;
    logic               out_free;

    // value store
    rcv_store #(
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (s_tdata[VALUE_W-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared compare and count unit
    rcv_rank_unit u_rank (
        .aclk    (aclk),
        .ctrl    (ctrl_reg),
        .rd_data (rd_data),
        .rank    (rank)
    );

    // load side
    assign s_tready  = (state_reg == ST_LOAD);
    assign s_accept  = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(MAX_ITEMS));
    assign wr_en     = s_accept && !full;
    assign count_inc = full ? count_reg : count_reg + CNT_W'(1);
    assign count_m1  = count_reg - CNT_W'(1);
    assign last_idx  = count_m1[IDX_W-1:0];
    assign out_free  = !m_valid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_i_next   = idx_i_reg;
        idx_j_next   = idx_j_reg;
        ctrl_next    = '0;
        rd_addr      = idx_i_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_rank_next  = m_rank_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    count_next = count_inc;
                    if (s_tlast) begin
                        idx_i_next = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                rd_addr            = idx_i_reg;
                ctrl_next.load_cur = 1'b1;
                idx_j_next         = '0;
                state_next         = ST_SWEEP;
            end
            ST_SWEEP: begin
                rd_addr          = idx_j_reg;
                ctrl_next.acc_en = 1'b1;
                if (idx_j_reg == last_idx) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_j_next = idx_j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rank_next  = rank;
                    m_last_next  = (idx_i_reg == last_idx);
                    if (idx_i_reg == last_idx) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_i_next = idx_i_reg + IDX_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            idx_i_reg   <= '0;
            idx_j_reg   <= '0;
            ctrl_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_i_reg   <= idx_i_next;
            idx_j_reg   <= idx_j_next;
            ctrl_reg    <= ctrl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        m_rank_reg <= m_rank_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_rank_reg);
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/rcv_store.sv
module rcv_store #(
    parameter int DEPTH = rcv_pkg::MAX_ITEMS_DEF
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [rcv_pkg::VALUE_W-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [rcv_pkg::VALUE_W-1:0] rd_data
);
    import rcv_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // one registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/rcv_rank_unit.sv
module rcv_rank_unit (
    input  logic                        aclk,
    input  rcv_pkg::rk_ctrl_t           ctrl,
    input  logic [rcv_pkg::VALUE_W-1:0] rd_data,
    output logic [rcv_pkg::RANK_W-1:0]  rank
);
    import rcv_pkg::*;

    logic [VALUE_W-1:0] cur_reg;
    logic [RANK_W-1:0]  acc_reg;
    logic [RANK_W-1:0]  acc_next;
    logic               less;

    // shared signed comparator
    assign less = $signed(rd_data) < $signed(cur_reg);

    // accumulate count of strictly smaller elements
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.load_cur) begin
            acc_next = '0;
        end else if (ctrl.acc_en) begin
            acc_next = acc_reg + RANK_W'(less);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_cur) begin
            cur_reg <= rd_data;
        end
        acc_reg <= acc_next;
    end

    assign rank = acc_reg;

endmodule

FILE: rtl/rcv_checker.sv
module rcv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rcv_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import rcv_pkg::*;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // rank fits its field, padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:RANK_W] == '0)
        else $error("padding bits set");

    // the final element starts ranking, no more items taken
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken after final element");

    // while a non-final rank is pending, loading stays closed
    a_busy_mid_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open before final rank");

endmodule

bind rank_compress_values_core rcv_checker u_rcv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
